@@ rtl/fpmw_pkg.sv @@
// Shared types and constants for the flash page merge writer.
`default_nettype none
package fpmw_pkg;

  localparam logic [15:0] ERASED_WORD = 16'hFFFF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CHK_RD,
    S_CHK_CMP,
    S_PRG_RD,
    S_PRG_WR,
    S_RESP
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic exec_write;
    logic rd_issue;
    logic chk_issue;
    logic chk_cmp;
    logic prg_issue;
    logic prg_write;
    logic resp_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic item_read;
    logic item_in_range;
    logic need_commit;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/fpmw_ctrl.sv @@
// Controller state machine for the flash page merge writer.
`default_nettype none
module fpmw_ctrl
  import fpmw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  fsm_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.item_read && stat.need_commit) state_nxt = S_CHK_RD;
        else state_nxt = S_RESP;
      end
      S_CHK_RD:  state_nxt = S_CHK_CMP;
      S_CHK_CMP: begin
        state_nxt = stat.sweep_last ? S_PRG_RD : S_CHK_RD;
      end
      S_PRG_RD:  state_nxt = S_PRG_WR;
      S_PRG_WR: begin
        state_nxt = stat.sweep_last ? S_RESP : S_PRG_RD;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.exec_write = !stat.item_read;
        cmd.rd_issue   = stat.item_read && stat.item_in_range;
      end
      S_CHK_RD:  cmd.chk_issue = 1'b1;
      S_CHK_CMP: cmd.chk_cmp   = 1'b1;
      S_PRG_RD:  cmd.prg_issue = 1'b1;
      S_PRG_WR:  cmd.prg_write = 1'b1;
      S_RESP:    cmd.resp_load = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/fpmw_datapath.sv @@
// Datapath: flash array, page image, run bookkeeping and result register.
`default_nettype none
module fpmw_datapath
  import fpmw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = 1024,
  parameter int unsigned FLASH_KBYTES = 128,
  parameter logic [31:0] FLASH_START  = 32'd134217728
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_byte_address,
  input  wire logic [15:0] in_halfword_in,
  input  wire logic        in_run_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_value,
  output logic [1:0]       out_status,
  output logic             out_page_erased,
  output logic             out_segment_committed,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat
);

  localparam int unsigned PW          = PAGE_BYTES / 2;
  localparam int unsigned PO_W        = $clog2(PW);
  localparam int unsigned FLASH_BYTES = FLASH_KBYTES * 1024;
  localparam int unsigned FW          = FLASH_BYTES / 2;
  localparam int unsigned FW_W        = $clog2(FW);
  localparam logic [PO_W-1:0] PW_LAST = PO_W'(PW - 1);
  localparam logic [FW_W-1:0] FW_LAST = FW_W'(FW - 1);

  // Memories.
  logic [15:0] flash_mem [FW];
  logic [15:0] page_mem  [PW];
  logic [15:0] flash_rd_r;
  logic [15:0] page_rd_r;

  // Latched item.
  logic        op_r;
  logic [31:0] addr_r;
  logic [15:0] data_r;
  logic        last_r;

  // Run state.
  logic            run_active_r, run_rej_r, past_end_r;
  logic [FW_W-1:0] cur_word_r;
  logic [PO_W-1:0] off_r, seg_r;

  // Commit sweep.
  logic [FW_W-1:0] base_r;
  logic [PO_W-1:0] idx_r, sw_start_r, sw_end_r;
  logic            blank_r;

  // Pending result.
  logic [1:0] res_status_r;
  logic       res_erased_r, res_done_r;
  logic       out_valid_r;
  logic [15:0] out_value_r;
  logic [1:0]  out_status_r;
  logic        out_erased_r, out_done_r;

  logic [FW_W-1:0] clr_idx_r;

  // Locate the latched address inside the flash.
  logic [32:0]     diff;
  logic            in_range;
  logic [FW_W-1:0] loc_word;
  assign diff     = {1'b0, addr_r[31:1], 1'b0} - {1'b0, FLASH_START};
  assign in_range = !diff[32] && (diff[31:0] < 32'(FLASH_BYTES));
  assign loc_word = diff[FW_W:1];

  // Effective run state for the current write beat.
  logic            start;
  logic            eff_rej, eff_past;
  logic [FW_W-1:0] eff_cur;
  logic [PO_W-1:0] eff_off, eff_seg;
  logic            commit;
  assign start    = !run_active_r;
  assign eff_rej  = start ? !in_range : run_rej_r;
  assign eff_past = start ? 1'b0 : past_end_r;
  assign eff_cur  = start ? loc_word : cur_word_r;
  assign eff_off  = start ? loc_word[PO_W-1:0] : off_r;
  assign eff_seg  = start ? loc_word[PO_W-1:0] : seg_r;
  assign commit   = !eff_rej && !eff_past &&
                    ((eff_off == PW_LAST) || (eff_cur == FW_LAST) || last_r);

  assign stat.clr_last      = (clr_idx_r == FW_LAST);
  assign stat.item_read     = (op_r == OP_READ);
  assign stat.item_in_range = in_range;
  assign stat.need_commit   = commit;
  assign stat.sweep_last    = (idx_r == sw_end_r);
  assign stat.out_free      = !out_valid_r || !out_stall;

  logic [FW_W-1:0] sweep_addr;
  assign sweep_addr = base_r + FW_W'(idx_r);

  // Flash array: one access per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      flash_mem[clr_idx_r] <= ERASED_WORD;
    end else if (cmd.prg_write) begin
      flash_mem[sweep_addr] <= page_rd_r;
    end else if (cmd.rd_issue) begin
      flash_rd_r <= flash_mem[loc_word];
    end else if (cmd.chk_issue) begin
      flash_rd_r <= flash_mem[sweep_addr];
    end
  end

  // Page image.
  always_ff @(posedge clk) begin
    if (cmd.exec_write && !eff_rej && !eff_past) begin
      page_mem[eff_off] <= data_r;
    end else if (cmd.prg_issue) begin
      page_rd_r <= page_mem[idx_r];
    end
  end

  // Clear counter after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step && !stat.clr_last) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Item latch and sweep payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      addr_r <= in_byte_address;
      data_r <= in_halfword_in;
      last_r <= in_run_last;
    end
    if (cmd.exec_write) begin
      res_status_r <= eff_rej ? ST_REJECTED : (eff_past ? ST_DROPPED : ST_OK);
      res_erased_r <= 1'b0;
      res_done_r   <= commit;
      base_r       <= eff_cur - FW_W'(eff_off);
      sw_start_r   <= eff_seg;
      sw_end_r     <= eff_off;
      idx_r        <= eff_seg;
      blank_r      <= 1'b1;
    end
    if (cmd.chk_cmp) begin
      if (flash_rd_r != ERASED_WORD) blank_r <= 1'b0;
      idx_r <= stat.sweep_last ? sw_start_r : idx_r + 1'b1;
    end
    if (cmd.prg_write) begin
      idx_r        <= idx_r + 1'b1;
      res_erased_r <= !blank_r;
    end
  end

  // Run bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      run_rej_r    <= 1'b0;
      past_end_r   <= 1'b0;
      cur_word_r   <= '0;
      off_r        <= '0;
      seg_r        <= '0;
    end else if (cmd.exec_write) begin
      if (last_r) begin
        run_active_r <= 1'b0;
        run_rej_r    <= 1'b0;
        past_end_r   <= 1'b0;
        off_r        <= '0;
        seg_r        <= '0;
        cur_word_r   <= eff_cur + 1'b1;
      end else begin
        run_active_r <= 1'b1;
        run_rej_r    <= eff_rej;
        if (eff_rej || eff_past) begin
          past_end_r <= eff_past;
          cur_word_r <= eff_cur;
          off_r      <= eff_off;
          seg_r      <= eff_seg;
        end else if (commit) begin
          past_end_r <= (eff_cur == FW_LAST);
          cur_word_r <= eff_cur + 1'b1;
          off_r      <= '0;
          seg_r      <= '0;
        end else begin
          past_end_r <= 1'b0;
          cur_word_r <= eff_cur + 1'b1;
          off_r      <= eff_off + 1'b1;
          seg_r      <= eff_seg;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      if (op_r == OP_READ) begin
        out_value_r  <= in_range ? flash_rd_r : 16'd0;
        out_status_r <= in_range ? ST_OK : ST_REJECTED;
        out_erased_r <= 1'b0;
        out_done_r   <= 1'b0;
      end else begin
        out_value_r  <= 16'd0;
        out_status_r <= res_status_r;
        out_erased_r <= res_done_r && res_erased_r;
        out_done_r   <= res_done_r;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_value        = out_value_r;
  assign out_status            = out_status_r;
  assign out_page_erased       = out_erased_r;
  assign out_segment_committed = out_done_r;

endmodule
`default_nettype wire

@@ rtl/flash_page_merge_writer_core.sv @@
// A read beat is latched, reads its flash word, then loads the result register. A write
// beat writes the page image; if it closes a segment, a check pass and then a program pass
// sweep the segment words before the result is loaded. One beat is in work at a time.
// After reset the single-port array is cleared to erased, one word per cycle, covering all
// FLASH_KBYTES*512 words; no beat is accepted until it ends. Reset is synchronous, active low.
`default_nettype none
module flash_page_merge_writer_core
  import fpmw_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = 1024,
  parameter int unsigned FLASH_KBYTES = 128,
  parameter logic [31:0] FLASH_START  = 32'd134217728
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_byte_address,
  input  wire logic [15:0] in_halfword_in,
  input  wire logic        in_run_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_value,
  output logic [1:0]       out_status,
  output logic             out_page_erased,
  output logic             out_segment_committed
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  fpmw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path.
  fpmw_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .FLASH_KBYTES (FLASH_KBYTES),
    .FLASH_START  (FLASH_START)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_opcode             (in_opcode),
    .in_byte_address       (in_byte_address),
    .in_halfword_in        (in_halfword_in),
    .in_run_last           (in_run_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_read_value        (out_read_value),
    .out_status            (out_status),
    .out_page_erased       (out_page_erased),
    .out_segment_committed (out_segment_committed),
    .cmd                   (cmd),
    .stat                  (stat)
  );

endmodule
`default_nettype wire
